// ===== hdl/lfs_pkg.sv =====
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared types and constants of the lens focus search controller.
// ----------------------------------------------------------------------------
package lfs_pkg;

	// default widths
	localparam int SETTING_BITS_DEF = 12;
	localparam int SCORE_BITS_DEF   = 16;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_ENABLE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_COARSE_STEP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_SETTING = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ZERO    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ONE     = 3'd6;

	// register defaults
	localparam int COARSE_STEP_DEF = 16;
	localparam int LEVEL_ONE_DEF   = 1;

	// step of the near-side widening search
	localparam int NEAR_STEP = -10;

	// input item kinds
	localparam logic FUNC_START = 1'b0;
	localparam logic FUNC_SCORE = 1'b1;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_CHECK  = 3'd1,
		PH_COARSE = 3'd2,
		PH_FAR    = 3'd3,
		PH_NEAR   = 3'd4,
		PH_BISECT = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_CAPTURE = 2'd0,
		ST_DONE    = 2'd1,
		ST_FAIL    = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	// control part of one result
	typedef struct packed {
		status_t status;
		logic    save;
	} res_ctl_t;

endpackage

// ===== hdl/lfs_step.sv =====
// ----------------------------------------------------------------------------
// lfs_step
// Next-state and result logic of the focus search for one item.
// ----------------------------------------------------------------------------
module lfs_step #(
	parameter int SETTING_BITS = lfs_pkg::SETTING_BITS_DEF,
	parameter int SCORE_BITS   = lfs_pkg::SCORE_BITS_DEF
) (
	// item
	input  logic                           func,
	input  logic [SCORE_BITS-1:0]          score,
	// configuration
	input  logic                           search_enable,
	input  logic [SETTING_BITS-1:0]        min_setting,
	input  logic [SETTING_BITS-1:0]        max_setting,
	input  logic [SETTING_BITS-2:0]        coarse_step,
	input  logic [SETTING_BITS-1:0]        start_setting,
	input  logic [SCORE_BITS-1:0]          level_zero,
	input  logic [SCORE_BITS-1:0]          level_one,
	// current state
	input  lfs_pkg::phase_t                phase,
	input  logic [SETTING_BITS-1:0]        probe,
	input  logic [SETTING_BITS-1:0]        low_end,
	input  logic [SETTING_BITS-1:0]        high_end,
	input  logic signed [SETTING_BITS:0]   step,
	input  logic                           reversed,
	input  logic [SCORE_BITS-1:0]          last_score,
	input  logic [SCORE_BITS-1:0]          first_score,
	// next state
	output lfs_pkg::phase_t                phase_n,
	output logic [SETTING_BITS-1:0]        probe_n,
	output logic [SETTING_BITS-1:0]        low_n,
	output logic [SETTING_BITS-1:0]        high_n,
	output logic signed [SETTING_BITS:0]   step_n,
	output logic                           rev_n,
	output logic [SCORE_BITS-1:0]          last_n,
	output logic [SCORE_BITS-1:0]          first_n,
	// result
	output lfs_pkg::res_ctl_t              res_ctl,
	output logic [SETTING_BITS-1:0]        res_setting
);

	localparam int STEP_W = SETTING_BITS + 1;
	localparam int SUM_W  = SETTING_BITS + 2;
	localparam logic signed [STEP_W-1:0] NEAR_S = STEP_W'(lfs_pkg::NEAR_STEP);

	// base + step, clamped: low limit tested first, then high limit
	function automatic logic [SETTING_BITS-1:0] clamp_add(
		input logic [SETTING_BITS-1:0]   base,
		input logic signed [STEP_W-1:0]  stp,
		input logic [SETTING_BITS-1:0]   lo_lim,
		input logic [SETTING_BITS-1:0]   hi_lim
	);
		logic signed [SUM_W-1:0] sum;
		logic [SETTING_BITS-1:0] r;
		sum = $signed({2'b00, base}) + $signed({stp[STEP_W-1], stp});
		if (sum < $signed({2'b00, lo_lim}))
			r = lo_lim;
		else if (sum > $signed({2'b00, hi_lim}))
			r = hi_lim;
		else
			r = sum[SETTING_BITS-1:0];
		return r;
	endfunction

	logic                           widen;
	logic [SETTING_BITS-1:0]        widen_at;
	logic                           do_move;
	lfs_pkg::phase_t                move_kind;
	logic [SETTING_BITS-1:0]        move_base;
	logic [SETTING_BITS-1:0]        nx;
	logic [SETTING_BITS-1:0]        nx_retry;
	logic                           do_bisect;
	logic                           do_fail;
	logic [SETTING_BITS:0]          mid_lim;
	logic [SETTING_BITS:0]          bis_sum;
	logic signed [STEP_W-1:0]       coarse_s;

	assign coarse_s = $signed({2'b00, coarse_step});
	assign mid_lim  = ({1'b0, min_setting} + {1'b0, max_setting}) >> 1;

	always_comb begin
		phase_n     = phase;
		probe_n     = probe;
		low_n       = low_end;
		high_n      = high_end;
		step_n      = step;
		rev_n       = reversed;
		last_n      = last_score;
		first_n     = first_score;
		res_ctl     = '{status: lfs_pkg::ST_CAPTURE, save: 1'b0};
		res_setting = '0;
		widen       = 1'b0;
		widen_at    = '0;
		do_move     = 1'b0;
		move_kind   = lfs_pkg::PH_COARSE;
		move_base   = '0;
		nx          = '0;
		nx_retry    = '0;
		do_bisect   = 1'b0;
		do_fail     = 1'b0;
		bis_sum     = '0;

		// phase decision
		if (func == lfs_pkg::FUNC_START) begin
			res_setting = start_setting;
			if (!search_enable) begin
				phase_n = lfs_pkg::PH_IDLE;
				res_ctl.status = lfs_pkg::ST_DONE;
			end else begin
				phase_n = lfs_pkg::PH_CHECK;
			end
		end else begin
			case (phase)
				lfs_pkg::PH_CHECK: begin
					first_n = score;
					if (score < level_one) begin
						widen    = 1'b1;
						widen_at = start_setting;
					end else begin
						phase_n = lfs_pkg::PH_COARSE;
						probe_n = start_setting;
						step_n  = ({1'b0, start_setting} < mid_lim) ? coarse_s : -coarse_s;
						rev_n   = 1'b0;
						last_n  = score;
						do_move = 1'b1;
					end
				end
				lfs_pkg::PH_COARSE: begin
					if (score < level_one) begin
						widen    = 1'b1;
						widen_at = probe;
					end else if (score > last_score) begin
						if (reversed) begin
							do_fail = 1'b1;
						end else begin
							step_n  = -step;
							probe_n = start_setting;
							rev_n   = 1'b1;
							last_n  = first_score;
							do_move = 1'b1;
						end
					end else begin
						if (score < last_score) begin
							last_n = score;
							rev_n  = 1'b1;
						end
						do_move = 1'b1;
					end
				end
				lfs_pkg::PH_FAR: begin
					if (score >= level_one) begin
						high_n    = low_end;
						step_n    = step >>> 1;
						do_move   = 1'b1;
						move_kind = lfs_pkg::PH_FAR;
					end else if (score == level_zero) begin
						do_move   = 1'b1;
						move_kind = lfs_pkg::PH_FAR;
					end else begin
						phase_n   = lfs_pkg::PH_BISECT;
						do_bisect = 1'b1;
					end
				end
				lfs_pkg::PH_NEAR: begin
					if (score == level_zero || score >= level_one) begin
						phase_n   = lfs_pkg::PH_BISECT;
						do_bisect = 1'b1;
					end else begin
						high_n    = low_end;
						do_move   = 1'b1;
						move_kind = lfs_pkg::PH_NEAR;
					end
				end
				lfs_pkg::PH_BISECT: begin
					if (score == level_zero || score >= level_one)
						low_n = probe;
					else
						high_n = probe;
					do_bisect = 1'b1;
				end
				default: begin
					phase_n = lfs_pkg::PH_IDLE;
					res_ctl.status = lfs_pkg::ST_IGNORED;
				end
			endcase
		end

		// near focus reached: pick far or near widening
		if (widen) begin
			low_n   = widen_at;
			high_n  = widen_at;
			do_move = 1'b1;
			if (score == level_zero) begin
				phase_n   = lfs_pkg::PH_FAR;
				step_n    = $signed({3'b000, coarse_step[SETTING_BITS-2:1]});
				move_kind = lfs_pkg::PH_FAR;
			end else begin
				phase_n   = lfs_pkg::PH_NEAR;
				step_n    = NEAR_S;
				move_kind = lfs_pkg::PH_NEAR;
			end
		end

		// one clamped move from the selected end
		if (do_move) begin
			case (move_kind)
				lfs_pkg::PH_FAR:  move_base = high_n;
				lfs_pkg::PH_NEAR: move_base = low_n;
				default:          move_base = probe_n;
			endcase
			nx = clamp_add(move_base, step_n, min_setting, max_setting);
			if (nx != move_base) begin
				res_setting = nx;
				case (move_kind)
					lfs_pkg::PH_FAR:  high_n = nx;
					lfs_pkg::PH_NEAR: low_n = nx;
					default:          probe_n = nx;
				endcase
			end else if (move_kind != lfs_pkg::PH_COARSE || rev_n) begin
				do_fail = 1'b1;
			end else begin
				// coarse search blocked: reverse once from the start setting
				nx_retry = clamp_add(start_setting, -step_n, min_setting, max_setting);
				step_n   = -step_n;
				rev_n    = 1'b1;
				last_n   = first_n;
				probe_n  = start_setting;
				if (nx_retry != start_setting) begin
					probe_n     = nx_retry;
					res_setting = nx_retry;
				end else begin
					do_fail = 1'b1;
				end
			end
		end

		// bisection step or finish
		if (do_bisect) begin
			if ({1'b0, low_n} + 1'b1 >= {1'b0, high_n}) begin
				phase_n        = lfs_pkg::PH_IDLE;
				res_ctl.status = lfs_pkg::ST_DONE;
				res_ctl.save   = (low_n != start_setting);
				res_setting    = low_n;
			end else begin
				bis_sum     = {1'b0, low_n} + {1'b0, high_n};
				probe_n     = bis_sum[SETTING_BITS:1];
				res_setting = bis_sum[SETTING_BITS:1];
			end
		end

		// failure restores the start setting
		if (do_fail) begin
			phase_n        = lfs_pkg::PH_IDLE;
			res_ctl.status = lfs_pkg::ST_FAIL;
			res_ctl.save   = 1'b0;
			res_setting    = start_setting;
		end
	end

endmodule

// ===== hdl/lens_focus_search_controller.sv =====
// ----------------------------------------------------------------------------
// lens_focus_search_controller
// Autofocus search: coarse hill climb, widening and bisection over lens settings.
// ----------------------------------------------------------------------------
// Path: the input register, then the result register; both hold while the result
//   output is stalled.
// Throughput: one item per cycle while results are taken; the search state
//   updates as an item leaves the input register, where the next item sees it.
// Reset: arst_n clears the search to idle and loads register defaults.
module lens_focus_search_controller #(
	parameter int SETTING_BITS = lfs_pkg::SETTING_BITS_DEF,
	parameter int SCORE_BITS   = lfs_pkg::SCORE_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// input items
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [((SCORE_BITS+7)/8)*8-1:0]         s_axis_tdata,  // focus_score
	input  logic                                    s_axis_tuser,  // func
	// results
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	output logic [((SETTING_BITS+8)/8)*8-1:0]       m_axis_tdata,  // lens_setting, save flag
	output logic [1:0]                              m_axis_tuser,  // status
	// configuration writes
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [lfs_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [((SETTING_BITS > SCORE_BITS) ? SETTING_BITS : SCORE_BITS)-1:0] cfg_data
);

	localparam int OUT_DATA_W = ((SETTING_BITS + 8) / 8) * 8;

	// configuration registers
	logic                           search_enable_q;
	logic [SETTING_BITS-1:0]        min_setting_q;
	logic [SETTING_BITS-1:0]        max_setting_q;
	logic [SETTING_BITS-2:0]        coarse_step_q;
	logic [SETTING_BITS-1:0]        start_setting_q;
	logic [SCORE_BITS-1:0]          level_zero_q;
	logic [SCORE_BITS-1:0]          level_one_q;

	// search state
	lfs_pkg::phase_t                phase_q, phase_n;
	logic [SETTING_BITS-1:0]        probe_q, probe_n;
	logic [SETTING_BITS-1:0]        low_q, low_n;
	logic [SETTING_BITS-1:0]        high_q, high_n;
	logic signed [SETTING_BITS:0]   step_q, step_n;
	logic                           rev_q, rev_n;
	logic [SCORE_BITS-1:0]          last_q, last_n;
	logic [SCORE_BITS-1:0]          first_q, first_n;

	// pipeline
	logic                           valid_s1;
	logic                           func_s1;
	logic [SCORE_BITS-1:0]          score_s1;
	logic                           valid_s2;
	lfs_pkg::res_ctl_t              res_s2;
	logic [SETTING_BITS-1:0]        setting_s2;
	lfs_pkg::res_ctl_t              res_ctl;
	logic [SETTING_BITS-1:0]        res_setting;
	logic                           advance;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.status;
	assign m_axis_tdata  = OUT_DATA_W'({res_s2.save, setting_s2});

	// configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_enable_q <= 1'b1;
			min_setting_q   <= '0;
			max_setting_q   <= '1;
			coarse_step_q   <= (SETTING_BITS-1)'(lfs_pkg::COARSE_STEP_DEF);
			start_setting_q <= '0;
			level_zero_q    <= '0;
			level_one_q     <= SCORE_BITS'(lfs_pkg::LEVEL_ONE_DEF);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lfs_pkg::CFG_SEARCH_ENABLE: search_enable_q <= cfg_data[0];
				lfs_pkg::CFG_LOW_LIMIT:     min_setting_q   <= cfg_data[SETTING_BITS-1:0];
				lfs_pkg::CFG_HIGH_LIMIT:    max_setting_q   <= cfg_data[SETTING_BITS-1:0];
				lfs_pkg::CFG_COARSE_STEP:   coarse_step_q   <= cfg_data[SETTING_BITS-2:0];
				lfs_pkg::CFG_START_SETTING: start_setting_q <= cfg_data[SETTING_BITS-1:0];
				lfs_pkg::CFG_LEVEL_ZERO:    level_zero_q    <= cfg_data[SCORE_BITS-1:0];
				lfs_pkg::CFG_LEVEL_ONE:     level_one_q     <= cfg_data[SCORE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			func_s1  <= s_axis_tuser;
			score_s1 <= s_axis_tdata[SCORE_BITS-1:0];
		end
	end

	// step logic
	lfs_step #(
		.SETTING_BITS(SETTING_BITS),
		.SCORE_BITS  (SCORE_BITS)
	) u_step (
		.func         (func_s1),
		.score        (score_s1),
		.search_enable(search_enable_q),
		.min_setting  (min_setting_q),
		.max_setting  (max_setting_q),
		.coarse_step  (coarse_step_q),
		.start_setting(start_setting_q),
		.level_zero   (level_zero_q),
		.level_one    (level_one_q),
		.phase        (phase_q),
		.probe        (probe_q),
		.low_end      (low_q),
		.high_end     (high_q),
		.step         (step_q),
		.reversed     (rev_q),
		.last_score   (last_q),
		.first_score  (first_q),
		.phase_n      (phase_n),
		.probe_n      (probe_n),
		.low_n        (low_n),
		.high_n       (high_n),
		.step_n       (step_n),
		.rev_n        (rev_n),
		.last_n       (last_n),
		.first_n      (first_n),
		.res_ctl      (res_ctl),
		.res_setting  (res_setting)
	);

	// search state update as an item leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lfs_pkg::PH_IDLE;
			probe_q <= '0;
			low_q   <= '0;
			high_q  <= '0;
			step_q  <= '0;
			rev_q   <= 1'b0;
			last_q  <= '0;
			first_q <= '0;
		end else if (advance) begin
			phase_q <= phase_n;
			probe_q <= probe_n;
			low_q   <= low_n;
			high_q  <= high_n;
			step_q  <= step_n;
			rev_q   <= rev_n;
			last_q  <= last_n;
			first_q <= first_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2     <= res_ctl;
			setting_s2 <= res_setting;
		end
	end

	// checks
	a_end_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (res_ctl.status == lfs_pkg::ST_FAIL || res_ctl.status == lfs_pkg::ST_DONE)
		|=> phase_q == lfs_pkg::PH_IDLE)
		else $error("search did not return to idle after done or fail");

	a_ignored_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_ctl.status == lfs_pkg::ST_IGNORED
		|-> phase_q == lfs_pkg::PH_IDLE && func_s1 == lfs_pkg::FUNC_SCORE)
		else $error("score ignored outside idle");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> valid_s1 && valid_s2 && !m_axis_tready)
		else $error("input stalled with room in the pipeline");

	a_save_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.status != lfs_pkg::ST_DONE |-> !res_s2.save)
		else $error("save flag outside a done result");

endmodule

// ===== bench/focus_search_checker.sv =====
// ----------------------------------------------------------------------------
// focus_search_checker
// Watches the item, result and register channels of the lens focus search
// controller, predicts every result from its own copy of the search state and
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module focus_search_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // focus_score
	input  logic        s_axis_tuser,   // func
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,   // lens_setting, save flag
	input  logic [1:0]  m_axis_tuser,   // status
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		lfs_pkg::status_t status;
		logic [11:0]      setting;
		logic             save;
	} focus_res_t;

	// register copy
	logic cfg_enable;
	int   cfg_low, cfg_high, cfg_step, cfg_start, cfg_lzero, cfg_lone;

	// search state copy
	lfs_pkg::phase_t ph;
	int              probe, lo_end, hi_end, step;
	logic            rev;
	int              last_sc, first_sc;

	focus_res_t  pending_focus_results[$];
	int          n_mismatch = 0;
	int          n_results  = 0;

	function automatic focus_res_t make_res(lfs_pkg::status_t st, int set, logic save);
		focus_res_t r;
		r.status  = st;
		r.setting = set[11:0];
		r.save    = save;
		return r;
	endfunction

	// low limit is tested first, so an inverted range pins low sums to low
	function automatic int clamp_to_limits(int v);
		if (v < cfg_low)
			return cfg_low;
		if (v > cfg_high)
			return cfg_high;
		return v;
	endfunction

	function automatic focus_res_t abort_search();
		ph = lfs_pkg::PH_IDLE;
		return make_res(lfs_pkg::ST_FAIL, cfg_start, 1'b0);
	endfunction

	// coarse step; one reversal back to the start setting is allowed
	function automatic focus_res_t coarse_advance();
		int nx;
		nx = clamp_to_limits(probe + step);
		if (nx != probe) begin
			probe = nx;
			return make_res(lfs_pkg::ST_CAPTURE, probe, 1'b0);
		end
		if (!rev) begin
			step    = -step;
			probe   = cfg_start;
			rev     = 1'b1;
			last_sc = first_sc;
			nx = clamp_to_limits(probe + step);
			if (nx != probe) begin
				probe = nx;
				return make_res(lfs_pkg::ST_CAPTURE, probe, 1'b0);
			end
		end
		return abort_search();
	endfunction

	function automatic focus_res_t far_advance();
		int nx;
		nx = clamp_to_limits(hi_end + step);
		if (nx == hi_end)
			return abort_search();
		hi_end = nx;
		return make_res(lfs_pkg::ST_CAPTURE, hi_end, 1'b0);
	endfunction

	function automatic focus_res_t near_advance();
		int nx;
		nx = clamp_to_limits(lo_end + step);
		if (nx == lo_end)
			return abort_search();
		lo_end = nx;
		return make_res(lfs_pkg::ST_CAPTURE, lo_end, 1'b0);
	endfunction

	function automatic focus_res_t bisect_advance();
		if (lo_end + 1 >= hi_end) begin
			ph = lfs_pkg::PH_IDLE;
			return make_res(lfs_pkg::ST_DONE, lo_end, lo_end != cfg_start);
		end
		probe = (lo_end + hi_end) / 2;
		return make_res(lfs_pkg::ST_CAPTURE, probe, 1'b0);
	endfunction

	// near focus found at setting f: exact level widens far, else near
	function automatic focus_res_t enter_widen(int s, int f);
		lo_end = f;
		hi_end = f;
		if (s == cfg_lzero) begin
			ph   = lfs_pkg::PH_FAR;
			step = cfg_step / 2;
			return far_advance();
		end
		ph   = lfs_pkg::PH_NEAR;
		step = lfs_pkg::NEAR_STEP;
		return near_advance();
	endfunction

	function automatic focus_res_t predict_focus_result(logic func, int s);
		if (func == lfs_pkg::FUNC_START) begin
			if (!cfg_enable) begin
				ph = lfs_pkg::PH_IDLE;
				return make_res(lfs_pkg::ST_DONE, cfg_start, 1'b0);
			end
			ph = lfs_pkg::PH_CHECK;
			return make_res(lfs_pkg::ST_CAPTURE, cfg_start, 1'b0);
		end
		case (ph)
			lfs_pkg::PH_CHECK: begin
				first_sc = s;
				if (s < cfg_lone)
					return enter_widen(s, cfg_start);
				ph      = lfs_pkg::PH_COARSE;
				probe   = cfg_start;
				step    = (cfg_start < (cfg_low + cfg_high) / 2) ? cfg_step : -cfg_step;
				rev     = 1'b0;
				last_sc = first_sc;
				return coarse_advance();
			end
			lfs_pkg::PH_COARSE: begin
				if (s < cfg_lone)
					return enter_widen(s, probe);
				if (s > last_sc) begin
					if (rev)
						return abort_search();
					step    = -step;
					probe   = cfg_start;
					rev     = 1'b1;
					last_sc = first_sc;
				end else if (s < last_sc) begin
					last_sc = s;
					rev     = 1'b1;
				end
				return coarse_advance();
			end
			lfs_pkg::PH_FAR: begin
				if (s >= cfg_lone) begin
					hi_end = lo_end;
					step   = step / 2;
					return far_advance();
				end
				if (s == cfg_lzero)
					return far_advance();
				ph = lfs_pkg::PH_BISECT;
				return bisect_advance();
			end
			lfs_pkg::PH_NEAR: begin
				if (s == cfg_lzero || s >= cfg_lone) begin
					ph = lfs_pkg::PH_BISECT;
					return bisect_advance();
				end
				hi_end = lo_end;
				return near_advance();
			end
			lfs_pkg::PH_BISECT: begin
				if (s == cfg_lzero || s >= cfg_lone)
					lo_end = probe;
				else
					hi_end = probe;
				return bisect_advance();
			end
			default: begin
				ph = lfs_pkg::PH_IDLE;
				return make_res(lfs_pkg::ST_IGNORED, 0, 1'b0);
			end
		endcase
	endfunction

	task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
		n_mismatch++;
		if (n_mismatch <= 100)
			$display("[%0t] result %0d: %s is %h, expected %h", $time, n_results, field,
				got, want);
	endtask

	// track transfers on all three channels
	always @(posedge clk or negedge arst_n) begin
		focus_res_t want;
		if (!arst_n) begin
			cfg_enable = 1'b1;
			cfg_low    = 0;
			cfg_high   = 4095;
			cfg_step   = lfs_pkg::COARSE_STEP_DEF;
			cfg_start  = 0;
			cfg_lzero  = 0;
			cfg_lone   = lfs_pkg::LEVEL_ONE_DEF;
			ph         = lfs_pkg::PH_IDLE;
			probe      = 0;
			lo_end     = 0;
			hi_end     = 0;
			step       = 0;
			rev        = 1'b0;
			last_sc    = 0;
			first_sc   = 0;
			pending_focus_results.delete();
		end else begin
			// results first: a result never belongs to an item of the same cycle
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_focus_results.size() == 0) begin
					report_mismatch("result with nothing pending", m_axis_tdata, 16'h0);
				end else begin
					want = pending_focus_results.pop_front();
					if (m_axis_tuser !== want.status)
						report_mismatch("status", 16'(m_axis_tuser), 16'(want.status));
					if (m_axis_tdata[11:0] !== want.setting)
						report_mismatch("lens_setting", 16'(m_axis_tdata[11:0]),
							16'(want.setting));
					if (m_axis_tdata[12] !== want.save)
						report_mismatch("save flag", 16'(m_axis_tdata[12]), 16'(want.save));
				end
				n_results++;
			end
			if (s_axis_tvalid && s_axis_tready)
				pending_focus_results.insert(pending_focus_results.size(),
					predict_focus_result(s_axis_tuser, s_axis_tdata));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lfs_pkg::CFG_SEARCH_ENABLE: cfg_enable = cfg_data[0];
					lfs_pkg::CFG_LOW_LIMIT:     cfg_low    = cfg_data[11:0];
					lfs_pkg::CFG_HIGH_LIMIT:    cfg_high   = cfg_data[11:0];
					lfs_pkg::CFG_COARSE_STEP:   cfg_step   = cfg_data[10:0];
					lfs_pkg::CFG_START_SETTING: cfg_start  = cfg_data[11:0];
					lfs_pkg::CFG_LEVEL_ZERO:    cfg_lzero  = cfg_data;
					lfs_pkg::CFG_LEVEL_ONE:     cfg_lone   = cfg_data;
					default: ;
				endcase
			end
		end
		// anything still pending counts against the run
		fail_count <= n_mismatch + pending_focus_results.size();
	end

endmodule

// ===== bench/tb_lens_focus_search_controller.sv =====
// ----------------------------------------------------------------------------
// tb_lens_focus_search_controller
// Drives start and score items into the focus search controller under a
// series of register settings: a short directed part, then biased random
// search sequences with random gaps and back-pressure. The checker module
// predicts and compares; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_lens_focus_search_controller;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int N_PHASES       = 12;
	localparam int PHASE_ITEMS    = 42;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;
	logic        s_axis_tuser  = lfs_pkg::FUNC_START;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index     = '0;
	logic [15:0] cfg_data      = '0;

	int   checker_failures;
	int   items_in      = 0;
	int   results_out   = 0;
	int   quiet_cycles  = 0;
	int   stall_left    = 0;
	logic idle_src      = 1'b1;
	logic idle_snk      = 1'b1;
	int   lvl_zero      = 0;
	int   lvl_one       = lfs_pkg::LEVEL_ONE_DEF;
	int   prev_score    = 0;

	lens_focus_search_controller i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	focus_search_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (checker_failures)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result back-pressure in bursts, started only while idle_snk is set
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left    <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_snk && $urandom_range(0, 4) == 0) begin
			stall_left    <= $urandom_range(0, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// transfer counts and watchdog
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			items_in <= items_in + 1;
		if (m_axis_tvalid && m_axis_tready)
			results_out <= results_out + 1;
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	task automatic send_item(logic func, logic [15:0] score);
		if (idle_src && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= score;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// cfg_valid stays high across back-to-back writes; caller lowers it
	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// the count of the last transfer is updated with a nonblocking assignment
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_out != items_in) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(logic en, int low, int high, int stp, int start, int lz,
			int l1);
		write_reg(lfs_pkg::CFG_SEARCH_ENABLE, {15'd0, en});
		write_reg(lfs_pkg::CFG_LOW_LIMIT, 16'(low));
		write_reg(lfs_pkg::CFG_HIGH_LIMIT, 16'(high));
		write_reg(lfs_pkg::CFG_COARSE_STEP, 16'(stp));
		write_reg(lfs_pkg::CFG_START_SETTING, 16'(start));
		write_reg(lfs_pkg::CFG_LEVEL_ZERO, 16'(lz));
		write_reg(lfs_pkg::CFG_LEVEL_ONE, 16'(l1));
		cfg_valid <= 1'b0;
		lvl_zero = lz;
		lvl_one  = l1;
	endtask

	// scores biased toward the thresholds and toward a falling trend
	task automatic next_score(output logic [15:0] sc);
		int m;
		int v;
		m = $urandom_range(0, 9);
		case (m)
			0, 1: v = lvl_zero;
			2, 3: v = (lvl_one == 0) ? $urandom_range(0, 65535) : $urandom_range(0, lvl_one - 1);
			4, 5: v = $urandom_range(lvl_one, 65535);
			6, 7: v = (prev_score > 64) ? prev_score - $urandom_range(1, 64) :
				$urandom_range(0, 65535);
			8:    v = (prev_score < 65471) ? prev_score + $urandom_range(1, 64) :
				$urandom_range(0, 65535);
			default: v = $urandom_range(0, 65535);
		endcase
		prev_score = v;
		sc = v[15:0];
	endtask

	task automatic pick_config(int p);
		logic en;
		int   low, high, stp, start, lz, l1;
		en    = ($urandom_range(0, 9) != 0);
		low   = $urandom_range(0, 1500);
		high  = $urandom_range(2500, 4095);
		stp   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2047) : $urandom_range(1, 64);
		start = $urandom_range(low, high);
		lz    = $urandom_range(0, 50);
		l1    = lz + $urandom_range(1, 3000);
		case (p)
			1: begin low = 0; high = 4095; stp = 2047; start = 4095; en = 1'b1; end
			2: begin low = 0; high = 4095; stp = 1; start = 0; en = 1'b1; end
			3: begin low = 4095; high = 4095; start = 4095; en = 1'b1; end
			4: begin low = 3000; high = 1000; start = $urandom_range(0, 4095); en = 1'b1; end
			5: begin lz = 65535; l1 = 65535; en = 1'b1; end
			6: begin lz = 0; l1 = 0; en = 1'b1; end
			7: en = 1'b0;
			8: begin low = 2000; high = 2100; start = 10; en = 1'b1; end
			9: begin
				low   = $urandom_range(0, 4095);
				high  = $urandom_range(0, 4095);
				start = $urandom_range(0, 4095);
				lz    = $urandom_range(0, 65535);
				l1    = $urandom_range(0, 65535);
			end
			default: ;
		endcase
		load_config(en, low, high, stp, start, lz, l1);
	endtask

	// start items each followed by a run of scores; now and then a stray score
	task automatic run_random_phase(int n_items);
		int          sent;
		int          len;
		logic [15:0] sc;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 19) == 0) begin
				send_item(lfs_pkg::FUNC_SCORE, 16'($urandom_range(0, 65535)));
				sent++;
			end else begin
				send_item(lfs_pkg::FUNC_START, 16'($urandom_range(0, 65535)));
				prev_score = $urandom_range(1000, 65535);
				len = $urandom_range(1, 24);
				for (int k = 0; k < len; k++) begin
					next_score(sc);
					send_item(lfs_pkg::FUNC_SCORE, sc);
				end
				sent += len + 1;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: scores while idle, far widening into bisection
		load_config(1'b1, 0, 4095, 16, 2000, 3, 40);
		send_item(lfs_pkg::FUNC_SCORE, 16'hFFFF);
		send_item(lfs_pkg::FUNC_SCORE, 16'h0000);
		send_item(lfs_pkg::FUNC_START, 16'h0000);
		send_item(lfs_pkg::FUNC_SCORE, 16'd3);
		send_item(lfs_pkg::FUNC_SCORE, 16'd3);
		send_item(lfs_pkg::FUNC_SCORE, 16'd20);
		send_item(lfs_pkg::FUNC_SCORE, 16'd50);
		send_item(lfs_pkg::FUNC_SCORE, 16'd10);
		send_item(lfs_pkg::FUNC_SCORE, 16'd50);
		// restart while busy, coarse climb that fails when the score rises after falling
		send_item(lfs_pkg::FUNC_START, 16'hFFFF);
		send_item(lfs_pkg::FUNC_SCORE, 16'd1000);
		send_item(lfs_pkg::FUNC_SCORE, 16'd900);
		send_item(lfs_pkg::FUNC_SCORE, 16'd950);
		// near widening into bisection to completion
		send_item(lfs_pkg::FUNC_START, 16'h0000);
		send_item(lfs_pkg::FUNC_SCORE, 16'd5);
		send_item(lfs_pkg::FUNC_SCORE, 16'd5);
		send_item(lfs_pkg::FUNC_SCORE, 16'd40);
		send_item(lfs_pkg::FUNC_SCORE, 16'd0);
		send_item(lfs_pkg::FUNC_SCORE, 16'hFFFF);
		send_item(lfs_pkg::FUNC_SCORE, 16'd7);
		wait_idle();

		// search disabled: immediate done, then a score is ignored
		load_config(1'b0, 0, 4095, 1, 4095, 3, 40);
		send_item(lfs_pkg::FUNC_START, 16'h1234);
		send_item(lfs_pkg::FUNC_SCORE, 16'h8000);
		wait_idle();

		// coarse step of one: far step halves to zero and the search fails
		load_config(1'b1, 0, 4095, 1, 4095, 3, 40);
		send_item(lfs_pkg::FUNC_START, 16'h0000);
		send_item(lfs_pkg::FUNC_SCORE, 16'd3);
		wait_idle();

		// random phases; the last ones run without idling
		for (int p = 1; p <= N_PHASES; p++) begin
			idle_src = (p < N_PHASES - 1) && (p % 3 != 0);
			idle_snk = (p < N_PHASES - 1) && (p % 4 != 1);
			pick_config(p);
			run_random_phase(PHASE_ITEMS);
			wait_idle();
		end

		repeat (10) @(posedge clk);
		if (checker_failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
